// ----- src/elfsl_pkg.sv -----
// Shared types and constants for the ELF segment layout block.
package elfsl_pkg;

  // Result kinds reported on the output channel.
  typedef enum logic [2:0] {
    KIND_LOAD     = 3'd0,
    KIND_RELRO    = 3'd1,
    KIND_STACK    = 3'd2,
    KIND_SKIP     = 3'd3,
    KIND_BADALIGN = 3'd4,
    KIND_XNOR     = 3'd5
  } kind_t;

  // Program header type words that the block recognizes.
  localparam logic [31:0] TYPE_LOAD  = 32'h0000_0001;
  localparam logic [31:0] TYPE_STACK = 32'h6474_e551;
  localparam logic [31:0] TYPE_RELRO = 32'h6474_e552;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned PAGE_W = 33;
  localparam logic [PAGE_W-1:0] PAGE_RESET = 33'd4096;

  // Remainder jobs run on the shared serial divider.
  typedef enum logic [2:0] {
    OP_ALPG,
    OP_DIFF,
    OP_VA,
    OP_OFF,
    OP_FSPAN,
    OP_RELRO
  } op_t;

  // Maps ELF flags (x, w, r from bit 0) onto access bits (r, w, x from bit 0).
  function automatic logic [2:0] map_access(input logic [2:0] f);
    return {f[0], f[1], f[2]};
  endfunction

endpackage

// ----- src/elf_segment_layout.sv -----
// Top level of the ELF program header load layout block.
//
// One program header enters per transfer on the s_ group: s_tuser holds the
// start-of-table flag and the header type, s_tdata the flags and the five
// 64-bit fields. One result leaves per header on the m_ group: m_tuser holds
// the record kind, m_tdata the layout fields. page_size is written through
// cfg_we / cfg_data while the block is idle; this binds the user, as the
// block itself does not enforce it. Every remainder is taken by one
// bit-serial restoring divider that retires one dividend bit per cycle. A
// LOAD header needs up to five remainders, a RELRO header one, a misaligned
// LOAD header one or two, an execute-without-read LOAD header two, and
// stack, skipped and zero-alignment headers none. One header is worked on
// at a time; s_tready is high only when no header is in work and rises as
// the result is registered. The finished result sits in an output register,
// so the next header is taken while it waits. If the receiver stalls, a
// finished header waits until the output register is free.
// Reset (rst, synchronous) sets page_size to 4096, clears the running table
// state and drops m_tvalid. There is no clearing pass.
module elf_segment_layout
  import elfsl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // page_size register
  input  logic         cfg_we,
  input  logic [32:0]  cfg_data,
  // Header stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tuser: start_of_table[0], header_type[32:1]
  input  logic [32:0]  s_tuser,
  // s_tdata: perm_flags[2:0], file_offset[66:3], virt_addr[130:67],
  // file_bytes[194:131], mem_bytes[258:195], alignment[322:259], zeros
  input  logic [327:0] s_tdata,
  // Result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tuser: record_kind[2:0]
  output logic [2:0]   m_tuser,
  // m_tdata: region_offset[63:0], file_start[127:64], file_span[191:128],
  // pad_start[255:192], pad_span[319:256], relro_span[383:320],
  // access[386:384], highest_end[450:387], exec_stack[451], zeros
  output logic [455:0] m_tdata
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t state;
  op_t    op;

  logic [PAGE_W-1:0] page_size;
  logic [WORD_W-1:0] first_base, max_end;
  logic              have_first, stack_exec, error_seen;

  // Latched header fields
  logic [2:0]        perm;
  logic [WORD_W-1:0] off, va, fsz, msz, al;

  // Working result
  kind_t             kind;
  logic [WORD_W-1:0] r_region, r_fstart, r_fspan, r_pstart, r_pspan, r_relro;
  logic [WORD_W-1:0] rem_va;
  logic [2:0]        r_access;

  // Serial divider
  logic [WORD_W-1:0] dvd, dvs, rem;
  logic [5:0]        cnt;
  logic [WORD_W:0]   trial;
  logic              ge;
  logic [WORD_W-1:0] rem_next;

  // Output register
  kind_t             o_kind;
  logic [WORD_W-1:0] o_region, o_fstart, o_fspan, o_pstart, o_pspan, o_relro, o_high;
  logic [2:0]        o_access;
  logic              o_stack;

  logic [WORD_W-1:0] pg;
  logic              sot;
  logic [31:0]       htype;

  assign pg    = (page_size == '0) ? {{(WORD_W-1){1'b0}}, 1'b1}
                                   : {{(WORD_W-PAGE_W){1'b0}}, page_size};
  assign sot   = s_tuser[0];
  assign htype = s_tuser[32:1];

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial    = {rem, dvd[WORD_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? WORD_W'(trial - {1'b0, dvs}) : trial[WORD_W-1:0];
  end

  assign s_tready = (state == S_IDLE);

  // Control, state registers and result registers.
  always_ff @(posedge clk) begin
    logic [WORD_W-1:0] fspan, mspan, base, region, real_end, endv;
    fspan    = fsz + rem_va;
    mspan    = msz + rem_va;
    base     = '0;
    region   = '0;
    real_end = '0;
    endv     = '0;
    if (rst) begin
      state      <= S_IDLE;
      page_size  <= PAGE_RESET;
      first_base <= '0;
      have_first <= 1'b0;
      max_end    <= '0;
      stack_exec <= 1'b0;
      error_seen <= 1'b0;
      m_tvalid   <= 1'b0;
      cnt        <= '0;
    end else begin
      if (cfg_we) begin
        page_size <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            perm     <= s_tdata[2:0];
            off      <= s_tdata[66:3];
            va       <= s_tdata[130:67];
            fsz      <= s_tdata[194:131];
            msz      <= s_tdata[258:195];
            al       <= s_tdata[322:259];
            r_region <= '0;
            r_fstart <= '0;
            r_fspan  <= '0;
            r_pstart <= '0;
            r_pspan  <= '0;
            r_relro  <= '0;
            r_access <= '0;
            rem_va   <= '0;
            kind     <= KIND_SKIP;
            state    <= S_DONE;
            rem      <= '0;
            cnt      <= '0;
            if (sot) begin
              first_base <= '0;
              have_first <= 1'b0;
              max_end    <= '0;
              stack_exec <= 1'b0;
              error_seen <= 1'b0;
            end
            if (!error_seen || sot) begin
              if (htype == TYPE_LOAD) begin
                if (s_tdata[258:195] != '0) begin
                  if (s_tdata[322:259] == '0) begin
                    kind       <= KIND_BADALIGN;
                    error_seen <= 1'b1;
                  end else begin
                    dvd   <= s_tdata[322:259];
                    dvs   <= pg;
                    op    <= OP_ALPG;
                    state <= S_DIV;
                  end
                end
              end else if (htype == TYPE_RELRO) begin
                dvd   <= s_tdata[130:67];
                dvs   <= pg;
                op    <= OP_RELRO;
                state <= S_DIV;
              end else if (htype == TYPE_STACK) begin
                kind       <= KIND_STACK;
                r_access   <= map_access(s_tdata[2:0]);
                stack_exec <= s_tdata[0];
              end
            end
          end
        end
        S_DIV: begin
          rem <= rem_next;
          dvd <= {dvd[WORD_W-2:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            // A remainder is ready; decide the next job.
            rem <= '0;
            cnt <= '0;
            dvs <= al;
            state <= S_DONE;
            unique case (op)
              OP_ALPG: begin
                if (rem_next != '0) begin
                  kind       <= KIND_BADALIGN;
                  error_seen <= 1'b1;
                end else begin
                  dvd   <= va - off;
                  op    <= OP_DIFF;
                  state <= S_DIV;
                end
              end
              OP_DIFF: begin
                if (rem_next != '0) begin
                  kind       <= KIND_BADALIGN;
                  error_seen <= 1'b1;
                end else if (perm[0] && !perm[2]) begin
                  kind       <= KIND_XNOR;
                  r_access   <= map_access(perm);
                  error_seen <= 1'b1;
                end else begin
                  dvd   <= va;
                  op    <= OP_VA;
                  state <= S_DIV;
                end
              end
              OP_VA: begin
                base = va - rem_next;
                if (have_first) begin
                  region = base - first_base;
                end else begin
                  have_first <= 1'b1;
                  first_base <= base;
                end
                endv = region + msz + rem_next;
                if (max_end < endv) begin
                  max_end <= endv;
                end
                rem_va   <= rem_next;
                r_region <= region;
                r_access <= map_access(perm);
                kind     <= KIND_LOAD;
                if (fsz != '0) begin
                  dvd   <= off;
                  op    <= OP_OFF;
                  state <= S_DIV;
                end else begin
                  r_pspan <= msz + rem_next;
                end
              end
              OP_OFF: begin
                r_fstart <= off - rem_next;
                r_fspan  <= fspan;
                if (msz > fsz) begin
                  dvd   <= fspan;
                  op    <= OP_FSPAN;
                  state <= S_DIV;
                end
              end
              OP_FSPAN: begin
                // Round the file span up to the alignment without a multiply.
                real_end = fspan - rem_next + ((rem_next != '0) ? al : '0);
                if (real_end < mspan) begin
                  r_pstart <= real_end;
                  r_pspan  <= mspan - real_end;
                end
              end
              OP_RELRO: begin
                kind     <= KIND_RELRO;
                r_region <= va - rem_next;
                r_relro  <= msz + rem_next;
              end
              default: begin
                kind <= KIND_SKIP;
              end
            endcase
          end
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (!m_tvalid || m_tready) begin
            o_kind   <= kind;
            o_region <= r_region;
            o_fstart <= r_fstart;
            o_fspan  <= r_fspan;
            o_pstart <= r_pstart;
            o_pspan  <= r_pspan;
            o_relro  <= r_relro;
            o_access <= r_access;
            o_high   <= max_end;
            o_stack  <= stack_exec;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = o_kind;
  assign m_tdata = {4'd0, o_stack, o_high, o_access, o_relro, o_pspan, o_pstart,
                    o_fspan, o_fstart, o_region};

`ifndef SYNTHESIS
  // A header transfer always starts work, so the input closes next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after a header transfer");

  // Only defined kinds leave the block.
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= KIND_XNOR)
    else $error("undefined record kind on output");

  // The divider counter only runs during a division.
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_DIV |-> cnt == 6'd0)
    else $error("divider counter running outside a division");
`endif

endmodule

// ----- tb/elf_segment_layout_test.sv -----
// Self-checking testbench for the ELF segment layout block.
module elf_segment_layout_test
  import elfsl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One program header as it travels on the input stream.
  typedef struct {
    logic        sot;
    logic [31:0] htype;
    logic [2:0]  flags;
    logic [63:0] off;
    logic [63:0] va;
    logic [63:0] fsz;
    logic [63:0] msz;
    logic [63:0] al;
  } header_t;

  // One layout record as it travels on the output stream.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] region;
    logic [63:0] fstart;
    logic [63:0] fspan;
    logic [63:0] pstart;
    logic [63:0] pspan;
    logic [63:0] rspan;
    logic [2:0]  acc;
    logic [63:0] hend;
    logic        xstack;
  } layout_t;

  // Directed stimulus row: a header, an optional typed-in record.
  typedef struct {
    header_t hdr;
    logic    fixed;
    layout_t rec;
  } row_t;

  localparam int unsigned LIMIT = 3_000_000;
  localparam int unsigned RAND_ITEMS = 1850;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [32:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [32:0]  s_tuser;
  logic [327:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [2:0]   m_tuser;
  logic [455:0] m_tdata;

  // Predictor state and page size.
  logic [32:0] pg_reg;
  logic [63:0] base0;
  logic        have_base;
  logic [63:0] end_max;
  logic        stack_x;
  logic        failed_tbl;

  layout_t layout_q[$];
  int unsigned errors;
  int unsigned cycles;
  bit          quiet;

  elf_segment_layout i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Turns ELF flags into access bits: read, write, execute from bit 0.
  function automatic logic [2:0] flags_to_access(input logic [2:0] f);
    logic [2:0] a;
    a[0] = f[2];
    a[1] = f[1];
    a[2] = f[0];
    return a;
  endfunction

  // Computes the layout record of one header and advances the table state.
  function automatic layout_t layout_of(input header_t h);
    layout_t     r;
    logic [63:0] pg, rem, base, fspan, mspan, pages, real_end, endv;
    logic [2:0]  acc;
    r = '{kind: KIND_SKIP, default: '0};
    pg = (pg_reg == 0) ? 64'd1 : 64'(pg_reg);
    if (h.sot) begin
      base0 = 0;
      have_base = 0;
      end_max = 0;
      stack_x = 0;
      failed_tbl = 0;
    end
    acc = flags_to_access(h.flags);
    if (!failed_tbl) begin
      if (h.htype == TYPE_LOAD && h.msz != 0) begin
        if (h.al == 0 || (h.al % pg) != 0 || ((h.va - h.off) % h.al) != 0) begin
          failed_tbl = 1;
          r.kind = KIND_BADALIGN;
        end else if (acc[2] && !acc[0]) begin
          failed_tbl = 1;
          r.kind = KIND_XNOR;
          r.acc = acc;
        end else begin
          r.kind = KIND_LOAD;
          rem = h.va % h.al;
          base = h.va - rem;
          if (!have_base) begin
            have_base = 1;
            base0 = base;
          end
          r.region = base - base0;
          fspan = h.fsz + rem;
          mspan = h.msz + rem;
          if (h.fsz != 0) begin
            r.fstart = h.off - (h.off % h.al);
            r.fspan = fspan;
            if (h.msz > h.fsz) begin
              pages = fspan / h.al + (((fspan % h.al) != 0) ? 64'd1 : 64'd0);
              real_end = pages * h.al;
              if (real_end < mspan) begin
                r.pstart = real_end;
                r.pspan = mspan - real_end;
              end
            end
          end else begin
            r.pspan = mspan;
          end
          r.acc = acc;
          endv = r.region + h.msz + rem;
          if (end_max < endv) end_max = endv;
        end
      end else if (h.htype == TYPE_RELRO) begin
        rem = h.va % pg;
        r.kind = KIND_RELRO;
        r.region = h.va - rem;
        r.rspan = h.msz + rem;
      end else if (h.htype == TYPE_STACK) begin
        r.kind = KIND_STACK;
        stack_x = acc[2];
        r.acc = acc;
      end
    end
    r.hend = end_max;
    r.xstack = stack_x;
    return r;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Random power of two up to 2^max_log.
  function automatic logic [63:0] pow2(input int unsigned max_log);
    return 64'd1 << $urandom_range(max_log, 0);
  endfunction

  // Mostly well-formed headers with random content; some noise.
  function automatic header_t random_header();
    header_t     h;
    logic [63:0] pg, al;
    int unsigned pick;
    pg = (pg_reg == 0) ? 64'd1 : 64'(pg_reg);
    h.sot = ($urandom_range(15, 0) == 0);
    h.flags = 3'($urandom);
    h.off = rnd64();
    h.va = rnd64();
    h.fsz = rnd64();
    h.msz = rnd64();
    h.al = rnd64();
    pick = $urandom_range(19, 0);
    if (pick < 12) begin
      h.htype = TYPE_LOAD;
      al = pg * pow2(4);
      if ($urandom_range(3, 0) == 0) al = pg * 64'($urandom_range(7, 1));
      h.al = al;
      h.off = {32'd0, $urandom} & ~64'hf;
      h.va = h.off + al * 64'($urandom_range(4096, 0));
      if ($urandom_range(9, 0) == 0) h.va = rnd64();
      h.fsz = 64'($urandom_range(3 * 32'(al[31:0] + 1), 0));
      if ($urandom_range(3, 0) == 0) h.fsz = 0;
      h.msz = h.fsz + 64'($urandom_range(65535, 0));
      if ($urandom_range(7, 0) == 0) h.msz = 0;
      if ($urandom_range(7, 0) == 0) h.msz = rnd64();
      if ($urandom_range(3, 0) != 0) h.flags[2] = 1'b1;
      if ($urandom_range(15, 0) == 0) h.al = 0;
    end else if (pick < 15) begin
      h.htype = TYPE_RELRO;
    end else if (pick < 17) begin
      h.htype = TYPE_STACK;
    end else begin
      h.htype = $urandom;
      h.htype[0] = pick[0];
    end
    return h;
  endfunction

  function automatic header_t hdr(input logic sot, input logic [31:0] t,
      input logic [2:0] f, input logic [63:0] off, input logic [63:0] va,
      input logic [63:0] fsz, input logic [63:0] msz, input logic [63:0] al);
    header_t h;
    h = '{sot, t, f, off, va, fsz, msz, al};
    return h;
  endfunction

  // Now and then holds the input side idle for a random burst, never when quiet.
  task automatic sender_gap();
    if (!quiet && $urandom_range(3, 0) == 0)
      repeat ($urandom_range(15, 1)) @(posedge clk);
  endtask

  // Sends one header and files its expected record.
  task automatic send_header(input header_t h, input logic fixed, input layout_t rec);
    layout_t p;
    sender_gap();
    p = layout_of(h);
    layout_q.push_back(fixed ? rec : p);
    s_tvalid <= 1'b1;
    s_tuser <= {h.htype, h.sot};
    s_tdata <= {5'd0, h.al, h.msz, h.fsz, h.va, h.off, h.flags};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    s_tvalid <= 1'b0;
    // The block is busy right after a transfer, so this edge costs nothing.
    @(posedge clk);
  endtask

  // Waits for the block to drain, then writes page_size.
  task automatic write_page(input logic [32:0] v);
    while (layout_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pg_reg = v;
  endtask

  // Receiver stalls in random bursts.
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(3, 0) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(15, 1) - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compares each record transfer with the oldest expectation.
  always @(posedge clk) begin
    layout_t e;
    layout_t a;
    if (!rst && m_tvalid && m_tready) begin
      a.kind = kind_t'(m_tuser);
      {a.xstack, a.hend, a.acc, a.rspan, a.pspan, a.pstart, a.fspan, a.fstart,
       a.region} = m_tdata[451:0];
      if (layout_q.size() == 0) begin
        $display("%0t: record with nothing expected, actual kind %0d", $time, a.kind);
        errors++;
      end else begin
        e = layout_q.pop_front();
        if (a !== e) begin
          errors++;
          $display("%0t: mismatch expected kind %0d reg %h fst %h fsp %h pst %h psp %h",
                   $time, e.kind, e.region, e.fstart, e.fspan, e.pstart, e.pspan);
          $display("%0t:   expected rsp %h acc %h hend %h xs %b", $time, e.rspan,
                   e.acc, e.hend, e.xstack);
          $display("%0t:   actual   kind %0d reg %h fst %h fsp %h pst %h psp %h",
                   $time, a.kind, a.region, a.fstart, a.fspan, a.pstart, a.pspan);
          $display("%0t:   actual   rsp %h acc %h hend %h xs %b", $time, a.rspan,
                   a.acc, a.hend, a.xstack);
        end
      end
    end
  end

  // Cycle limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    row_t        rows[$];
    row_t        rw;
    layout_t     none;
    logic [63:0] ones;
    logic [32:0] pages[5];
    ones = '1;
    none = '{kind: KIND_SKIP, default: '0};
    errors = 0;
    quiet = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    pg_reg = PAGE_RESET;
    base0 = 0; have_base = 0; end_max = 0; stack_x = 0; failed_tbl = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: typed-in records where obvious, else predicted.
    rw = '{hdr: hdr(1, 32'h0, 0, 0, 0, 0, 0, 0), fixed: 1, rec: none};
    rows.push_back(rw);
    // Zero memory size skips the header.
    rw = '{hdr: hdr(0, TYPE_LOAD, 3'b100, 0, 0, 5, 0, 4096), fixed: 1, rec: none};
    rows.push_back(rw);
    rw.fixed = 0;
    rw.hdr = hdr(0, TYPE_LOAD, 3'b101, 0, 64'h40_0000, 64'h1234, 64'h1234, 4096);
    rows.push_back(rw);
    rw.hdr = hdr(0, TYPE_LOAD, 3'b110, 64'h1f00, 64'h40_2f00, 64'h100, 64'h5000, 4096);
    rows.push_back(rw);
    rw.hdr = hdr(0, TYPE_LOAD, 3'b110, 64'h0, 64'h50_0000, 0, 64'h3000, 4096);
    rows.push_back(rw);
    rw.hdr = hdr(0, TYPE_RELRO, 3'b100, 0, 64'h40_2f10, 0, 64'h10f0, 0);
    rows.push_back(rw);
    rw.hdr = hdr(0, TYPE_STACK, 3'b111, 0, 0, 0, 0, 0);
    rows.push_back(rw);
    // Repeated stack header: the latest one wins.
    rw.hdr = hdr(0, TYPE_STACK, 3'b110, ones, ones, ones, ones, ones);
    rows.push_back(rw);
    rw.hdr = hdr(0, 32'hffff_ffff, 3'b111, ones, ones, ones, ones, ones);
    rows.push_back(rw);
    // Zero alignment is an error; later headers are skipped.
    rw.hdr = hdr(0, TYPE_LOAD, 3'b100, 0, 0, 1, 1, 0);
    rows.push_back(rw);
    rw.hdr = hdr(0, TYPE_STACK, 3'b111, 0, 0, 0, 0, 0);
    rows.push_back(rw);
    // Misaligned alignment against the page, then misaligned offset.
    rw = '{hdr: hdr(1, TYPE_LOAD, 3'b100, 0, 0, 1, 1, 100), fixed: 1,
           rec: '{kind: KIND_BADALIGN, default: '0}};
    rows.push_back(rw);
    rw.hdr = hdr(1, TYPE_LOAD, 3'b100, 1, 0, 1, 1, 4096);
    rows.push_back(rw);
    // Execute without read.
    rw = '{hdr: hdr(1, TYPE_LOAD, 3'b001, 0, 0, 1, 1, 4096), fixed: 1,
           rec: '{kind: KIND_XNOR, acc: 3'b100, default: '0}};
    rows.push_back(rw);
    rw.fixed = 0;
    // Wrapping arithmetic at the top of the address space.
    rw.hdr = hdr(1, TYPE_LOAD, 3'b111, 64'hffff_ffff_ffff_f000, ones, ones, ones, 4096);
    rows.push_back(rw);
    rw.hdr = hdr(0, TYPE_LOAD, 3'b100, 0, 64'h1000, 0, ones, 4096);
    rows.push_back(rw);
    rw.hdr = hdr(0, TYPE_RELRO, 3'b000, ones, ones, ones, ones, ones);
    rows.push_back(rw);
    rw.hdr = hdr(1, TYPE_LOAD, 3'b100, 64'h10, 64'h8000_0010, 64'h8, 64'h8, 64'h8000_0000);
    rows.push_back(rw);
    foreach (rows[i]) send_header(rows[i].hdr, rows[i].fixed, rows[i].rec);

    // Random headers over several page sizes, extremes included.
    pages[0] = 33'd1;
    pages[1] = 33'h1_0000_0000;
    pages[2] = 33'd0;
    pages[3] = 33'd64;
    pages[4] = 33'd4096;
    for (int p = 0; p < 5; p++) begin
      write_page(pages[p]);
      for (int i = 0; i < RAND_ITEMS / 5; i++) begin
        if (p == 4 && i > RAND_ITEMS / 5 - 60) quiet = 1;
        send_header(random_header(), 0, none);
      end
    end

    while (layout_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
